// File: design/pcrp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PCM clip player package
// Shared constants, codes and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package pcrp_pkg;

    localparam int unsigned OUT_RATE        = 16000;
    localparam int unsigned RELEASE_SAMPLES = OUT_RATE * 8 / 1000;
    localparam int unsigned MAX_SAMPLES     = 16000000;
    localparam int unsigned MIN_RATE        = 4000;
    localparam int unsigned MAX_RATE        = 48000;
    localparam int unsigned FADE_MAX        = 96;
    localparam int unsigned FADE_LIMIT      = 288;
    localparam int unsigned SMOOTH_K        = 196608;
    localparam int unsigned MIX_GAIN        = 15000;
    localparam int unsigned FULL_DIV_ITERS  = 38;
    localparam int unsigned FRAC_DIV_ITERS  = 16;
    // rate * 65536 / OUT_RATE = (rate * 512) / 125; ceil(2^32 / 125) makes
    // the multiply-and-shift exact for any 16-bit rate
    localparam int unsigned PHASE_RECIP     = 34359739;

    localparam logic REG_VOLUME  = 1'b0;
    localparam logic REG_ENABLED = 1'b1;

    typedef enum logic [1:0] {
        KIND_PLAY   = 2'd0,
        KIND_CANCEL = 2'd1,
        KIND_TICK   = 2'd2,
        KIND_NOP    = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_XA2,
        MUL_XR2,
        MUL_SA,
        MUL_SR,
        MUL_WAVE,
        MUL_ENV,
        MUL_GAIN15,
        MUL_REL,
        MUL_V2,
        MUL_V3
    } mul_op_t;

    typedef enum logic [1:0] {
        DIV_PHASE,
        DIV_DUR,
        DIV_FRAC_A,
        DIV_FRAC_R
    } div_op_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_PLAY,
        S_CANCEL,
        S_ST_DUR,
        S_ST_DUR_W,
        S_T_FA,
        S_T_FA_W,
        S_T_FR,
        S_T_FR_W,
        S_T_M1,
        S_T_M2,
        S_T_M3,
        S_T_M4,
        S_T_M5,
        S_T_M6,
        S_T_M7,
        S_T_M8,
        S_T_M9,
        S_T_M10,
        S_T_M11,
        S_T_M12,
        S_T_M13,
        S_T_UPD,
        S_FIN
    } state_t;

    typedef struct packed {
        logic    item_load;
        logic    play_exec;
        logic    cancel;
        logic    div_go;
        div_op_t div_op;
        mul_op_t mul_op;
        logic    gain_upd;
        logic    tick_upd;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  active;
        logic  play_start;
        logic  tick_restart;
        logic  div_done;
    } status_t;

endpackage
`default_nettype wire

// File: design/pcrp_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PCM clip player serial divider
// Restoring division, one quotient bit per cycle, with a preset remainder
// so that fractions n/d (n < d) come out in Q0.16 directly.
// ----------------------------------------------------------------------------
module pcrp_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        go,
    input  wire logic [15:0] rem_init,
    input  wire logic [37:0] dividend,
    input  wire logic [15:0] divisor,
    input  wire logic [5:0]  iters,
    output logic             done,
    output logic [37:0]      quotient
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [15:0] rem_reg, rem_next;
    logic [15:0] dsr_reg, dsr_next;
    logic [37:0] dvd_reg, dvd_next;
    logic [37:0] q_reg, q_next;
    logic [16:0] trial;
    logic        fits;

    always_comb
    begin
        trial     = {rem_reg, dvd_reg[37]};
        fits      = trial >= {1'b0, dsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        dvd_next  = dvd_reg;
        q_next    = q_reg;
        if (go)
        begin
            busy_next = 1'b1;
            cnt_next  = iters;
            rem_next  = rem_init;
            dsr_next  = divisor;
            dvd_next  = dividend;
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? 16'(trial - {1'b0, dsr_reg}) : trial[15:0];
            q_next   = {q_reg[36:0], fits};
            dvd_next = {dvd_reg[36:0], 1'b0};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        dvd_reg <= dvd_next;
        q_reg   <= q_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule
`default_nettype wire

// File: design/pcrp_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PCM clip player datapath
// Clip and pending state, shared multiplier, serial divider, envelope and
// gain arithmetic, fetch address generation and the result register.
// ----------------------------------------------------------------------------
module pcrp_datapath (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire pcrp_pkg::cmd_t     cmd,
    output pcrp_pkg::status_t       status,
    input  wire logic               cfg_we,
    input  wire logic               cfg_index,
    input  wire logic [7:0]         cfg_data,
    input  wire logic [1:0]         kind,
    input  wire logic [31:0]        clip_base,
    input  wire logic [23:0]        clip_samples,
    input  wire logic [15:0]        clip_rate,
    input  wire logic [1:0]         clip_encoding,
    input  wire logic [1:0]         priority_req,
    input  wire logic [7:0]         sample_a,
    input  wire logic [7:0]         sample_b,
    output logic signed [15:0]      audio_out,
    output logic                    rendered,
    output logic                    accepted,
    output logic                    playing,
    output logic [31:0]             fetch_addr_a,
    output logic [31:0]             fetch_addr_b
);

    // configuration
    logic [7:0]  volume_reg;
    logic        enabled_reg;

    // captured item
    logic [1:0]  kind_reg;
    logic [31:0] base_i_reg;
    logic [23:0] len_i_reg;
    logic [15:0] rate_i_reg;
    logic [1:0]  enc_i_reg;
    logic [1:0]  prio_i_reg;
    logic [7:0]  sa_i_reg;
    logic [7:0]  sb_i_reg;

    // clip state
    logic        active_reg;
    logic [31:0] cur_base_reg;
    logic [23:0] cur_len_reg;
    logic        cur_enc_reg;
    logic [1:0]  cur_prio_reg;
    logic [39:0] phase_acc_reg;
    logic [17:0] phase_step_reg;
    logic [27:0] pos_reg;
    logic [27:0] dur_reg;
    logic [7:0]  rl_reg;
    logic [16:0] gain_reg;
    logic [15:0] st_rate_reg;
    logic        pend_valid_reg;
    logic [31:0] pend_base_reg;
    logic [23:0] pend_len_reg;
    logic [15:0] pend_rate_reg;
    logic        pend_enc_reg;
    logic [1:0]  pend_prio_reg;

    // arithmetic temporaries
    pcrp_pkg::mul_op_t p_op_reg;
    pcrp_pkg::div_op_t div_dst_reg;
    logic signed [50:0] p_reg;
    logic [16:0] fa_reg, fr_reg, x2a_reg, x2r_reg, sa_reg, sr_reg, env_reg;
    logic signed [25:0] wave_reg;
    logic signed [31:0] v1_reg, v2_reg;
    logic signed [15:0] audio_reg;
    logic        rendered_reg, accepted_reg;

    // result register
    logic signed [15:0] audio_o_reg;
    logic        rendered_o_reg, accepted_o_reg, playing_o_reg;
    logic [31:0] addr_a_o_reg, addr_b_o_reg;

    function automatic logic signed [50:0] trunc_shr(input logic signed [50:0] p,
                                                     input int unsigned k);
        logic signed [50:0] bias;
        bias = p[50] ? ((51'sd1 <<< k) - 51'sd1) : 51'sd0;
        return (p + bias) >>> k;
    endfunction

    // play validation
    logic [1:0] occupied;
    logic       ok;
    always_comb
    begin
        occupied = pend_valid_reg ? pend_prio_reg : cur_prio_reg;
        ok = enabled_reg && (len_i_reg != 24'd0)
            && ({8'd0, len_i_reg} <= 32'(pcrp_pkg::MAX_SAMPLES))
            && ({16'd0, rate_i_reg} >= 32'(pcrp_pkg::MIN_RATE))
            && ({16'd0, rate_i_reg} <= 32'(pcrp_pkg::MAX_RATE))
            && (enc_i_reg <= 2'd1)
            && !(active_reg && (prio_i_reg < occupied));
    end

    // tick end
    logic [27:0] pos_inc;
    logic        released, ended;
    assign pos_inc  = pos_reg + 28'd1;
    assign released = (rl_reg == 8'd1);
    assign ended    = released || (pos_inc >= dur_reg);

    logic start_now, start_pend;
    assign start_pend = cmd.tick_upd;
    assign start_now  = (cmd.play_exec && ok && !active_reg)
                      || (cmd.tick_upd && active_reg && ended && pend_valid_reg);

    // phase step of the starting clip: rate * 512 / 125 by reciprocal
    logic [15:0] st_rate_sel;
    logic [50:0] step_prod;
    always_comb
    begin
        st_rate_sel = start_pend ? pend_rate_reg : rate_i_reg;
        step_prod   = 51'({st_rate_sel, 9'd0}) * 51'(pcrp_pkg::PHASE_RECIP);
    end

    // envelope fade length and remaining count
    logic [16:0] third;
    logic [15:0] fade;
    logic [27:0] rem_n;
    always_comb
    begin
        third = 17'(dur_reg[8:0]) * 17'd171;
        if (dur_reg < 28'(pcrp_pkg::FADE_LIMIT))
            fade = {8'd0, third[16:9]};
        else
            fade = 16'(pcrp_pkg::FADE_MAX);
        if (fade == 16'd0)
            fade = 16'd1;
        rem_n = (pos_reg < dur_reg) ? (dur_reg - 28'd1 - pos_reg) : 28'd0;
    end

    // divider
    logic [15:0] d_rem0, d_divisor;
    logic [37:0] d_dividend;
    logic [5:0]  d_iters;
    logic        d_done;
    logic [37:0] d_q;
    always_comb
    begin
        d_rem0     = 16'd0;
        d_dividend = 38'd0;
        d_divisor  = fade;
        d_iters    = 6'(pcrp_pkg::FRAC_DIV_ITERS);
        case (cmd.div_op)
            pcrp_pkg::DIV_DUR:
            begin
                d_dividend = 38'(cur_len_reg) * 38'(pcrp_pkg::OUT_RATE)
                           + 38'(st_rate_reg) - 38'd1;
                d_divisor  = st_rate_reg;
                d_iters    = 6'(pcrp_pkg::FULL_DIV_ITERS);
            end
            pcrp_pkg::DIV_FRAC_A: d_rem0 = pos_reg[15:0];
            pcrp_pkg::DIV_FRAC_R: d_rem0 = rem_n[15:0];
            default: d_rem0 = 16'd0;
        endcase
    end

    pcrp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (cmd.div_go),
        .rem_init (d_rem0),
        .dividend (d_dividend),
        .divisor  (d_divisor),
        .iters    (d_iters),
        .done     (d_done),
        .quotient (d_q)
    );

    // decoded samples
    logic signed [7:0] dec_a, dec_b;
    logic signed [8:0] d_ba;
    always_comb
    begin
        dec_a = cur_enc_reg ? $signed({~sa_i_reg[7], sa_i_reg[6:0]}) : $signed(sa_i_reg);
        dec_b = cur_enc_reg ? $signed({~sb_i_reg[7], sb_i_reg[6:0]}) : $signed(sb_i_reg);
        d_ba  = 9'(dec_b) - 9'(dec_a);
    end

    // multiplier operands
    logic signed [31:0] mul_a;
    logic signed [18:0] mul_b;
    logic [17:0] smk_a, smk_r;
    logic [7:0]  rl_dec;
    always_comb
    begin
        smk_a  = 18'(pcrp_pkg::SMOOTH_K) - {fa_reg, 1'b0};
        smk_r  = 18'(pcrp_pkg::SMOOTH_K) - {fr_reg, 1'b0};
        rl_dec = rl_reg - 8'd1;
        mul_a  = 32'sd0;
        mul_b  = 19'sd0;
        case (cmd.mul_op)
            pcrp_pkg::MUL_XA2:
            begin
                mul_a = $signed({15'd0, fa_reg});
                mul_b = $signed({2'd0, fa_reg});
            end
            pcrp_pkg::MUL_XR2:
            begin
                mul_a = $signed({15'd0, fr_reg});
                mul_b = $signed({2'd0, fr_reg});
            end
            pcrp_pkg::MUL_SA:
            begin
                mul_a = $signed({15'd0, x2a_reg});
                mul_b = $signed({1'b0, smk_a});
            end
            pcrp_pkg::MUL_SR:
            begin
                mul_a = $signed({15'd0, x2r_reg});
                mul_b = $signed({1'b0, smk_r});
            end
            pcrp_pkg::MUL_WAVE:
            begin
                mul_a = 32'(d_ba);
                mul_b = $signed({3'd0, phase_acc_reg[15:0]});
            end
            pcrp_pkg::MUL_ENV:
            begin
                mul_a = $signed({15'd0, sa_reg});
                mul_b = $signed({2'd0, sr_reg});
            end
            pcrp_pkg::MUL_GAIN15:
            begin
                mul_a = 32'(wave_reg);
                mul_b = 19'(pcrp_pkg::MIX_GAIN);
            end
            pcrp_pkg::MUL_REL:
            begin
                mul_a = $signed({15'd0, env_reg});
                mul_b = $signed({11'd0, rl_dec});
            end
            pcrp_pkg::MUL_V2:
            begin
                mul_a = v1_reg;
                mul_b = $signed({2'd0, env_reg});
            end
            pcrp_pkg::MUL_V3:
            begin
                mul_a = v2_reg;
                mul_b = $signed({2'd0, gain_reg});
            end
            default:
            begin
                mul_a = 32'sd0;
                mul_b = 19'sd0;
            end
        endcase
    end

    // product post-processing
    logic signed [50:0] p_t7, p_t16, p_t32;
    logic signed [15:0] sat_out;
    logic signed [25:0] wave_sum;
    always_comb
    begin
        p_t7     = trunc_shr(p_reg, 7);
        p_t16    = trunc_shr(p_reg, 16);
        p_t32    = trunc_shr(p_reg, 32);
        wave_sum = $signed({{2{dec_a[7]}}, dec_a, 16'd0}) + p_reg[25:0];
        if (p_t32 > 51'sd32767)
            sat_out = 16'sd32767;
        else if (p_t32 < -51'sd32768)
            sat_out = -16'sd32768;
        else
            sat_out = p_t32[15:0];
    end

    // gain smoothing: target = volume*65536/255
    logic [16:0] g_target;
    logic signed [17:0] g_diff, g_step, g_sum;
    always_comb
    begin
        g_target = {1'b0, volume_reg, volume_reg} + 17'(volume_reg == 8'hFF);
        g_diff   = $signed({1'b0, g_target}) - $signed({1'b0, gain_reg});
        g_step   = (g_diff + (g_diff[17] ? 18'sd63 : 18'sd0)) >>> 6;
        g_sum    = $signed({1'b0, gain_reg}) + g_step;
    end

    // fetch addresses
    logic [23:0] len1, idx, ia, ib;
    logic [24:0] ia_inc;
    always_comb
    begin
        len1   = (cur_len_reg == 24'd0) ? 24'd1 : cur_len_reg;
        idx    = phase_acc_reg[39:16];
        ia     = (idx >= len1) ? (len1 - 24'd1) : idx;
        ia_inc = {1'b0, ia} + 25'd1;
        ib     = (ia_inc < {1'b0, len1}) ? ia_inc[23:0] : ia;
    end

    logic [16:0] frac_q;
    assign frac_q = d_q[16:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            volume_reg     <= 8'hFF;
            enabled_reg    <= 1'b1;
            active_reg     <= 1'b0;
            cur_base_reg   <= '0;
            cur_len_reg    <= '0;
            cur_enc_reg    <= 1'b0;
            cur_prio_reg   <= '0;
            phase_acc_reg  <= '0;
            phase_step_reg <= '0;
            pos_reg        <= '0;
            dur_reg        <= '0;
            rl_reg         <= '0;
            gain_reg       <= '0;
            st_rate_reg    <= '0;
            pend_valid_reg <= 1'b0;
            pend_base_reg  <= '0;
            pend_len_reg   <= '0;
            pend_rate_reg  <= '0;
            pend_enc_reg   <= 1'b0;
            pend_prio_reg  <= '0;
            p_op_reg       <= pcrp_pkg::MUL_NONE;
            div_dst_reg    <= pcrp_pkg::DIV_PHASE;
            rendered_reg   <= 1'b0;
            accepted_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == pcrp_pkg::REG_VOLUME)
                    volume_reg <= cfg_data;
                else
                begin
                    enabled_reg <= cfg_data[0];
                    if (!cfg_data[0])
                    begin
                        pend_valid_reg <= 1'b0;
                        if (active_reg && rl_reg == 8'd0)
                            rl_reg <= 8'(pcrp_pkg::RELEASE_SAMPLES);
                    end
                end
            end

            if (cmd.item_load)
            begin
                rendered_reg <= 1'b0;
                accepted_reg <= 1'b0;
            end

            if (cmd.cancel)
            begin
                pend_valid_reg <= 1'b0;
                if (active_reg && rl_reg == 8'd0)
                    rl_reg <= 8'(pcrp_pkg::RELEASE_SAMPLES);
            end

            if (cmd.play_exec && ok)
            begin
                accepted_reg <= 1'b1;
                if (active_reg)
                begin
                    pend_valid_reg <= 1'b1;
                    pend_base_reg  <= base_i_reg;
                    pend_len_reg   <= len_i_reg;
                    pend_rate_reg  <= rate_i_reg;
                    pend_enc_reg   <= enc_i_reg[0];
                    pend_prio_reg  <= prio_i_reg;
                    if (rl_reg == 8'd0)
                        rl_reg <= 8'(pcrp_pkg::RELEASE_SAMPLES);
                end
            end

            if (cmd.tick_upd && active_reg)
            begin
                phase_acc_reg <= phase_acc_reg + {22'd0, phase_step_reg};
                pos_reg       <= pos_inc;
                if (rl_reg != 8'd0)
                    rl_reg <= rl_reg - 8'd1;
                if (ended)
                begin
                    active_reg <= 1'b0;
                    if (pend_valid_reg)
                        pend_valid_reg <= 1'b0;
                end
            end

            // new clip overrides the tick update above
            if (start_now)
            begin
                active_reg     <= 1'b1;
                cur_base_reg   <= start_pend ? pend_base_reg : base_i_reg;
                cur_len_reg    <= start_pend ? pend_len_reg : len_i_reg;
                cur_enc_reg    <= start_pend ? pend_enc_reg : enc_i_reg[0];
                cur_prio_reg   <= start_pend ? pend_prio_reg : prio_i_reg;
                st_rate_reg    <= st_rate_sel;
                phase_step_reg <= step_prod[49:32];
                phase_acc_reg  <= '0;
                pos_reg        <= '0;
                rl_reg         <= '0;
            end

            if (cmd.div_go)
                div_dst_reg <= cmd.div_op;

            if (d_done)
            begin
                case (div_dst_reg)
                    pcrp_pkg::DIV_DUR: dur_reg <= d_q[27:0];
                    default:           dur_reg <= dur_reg;
                endcase
            end

            if (cmd.gain_upd)
                gain_reg <= g_sum[16:0];

            p_op_reg <= cmd.mul_op;
            if (p_op_reg == pcrp_pkg::MUL_V3)
                rendered_reg <= 1'b1;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.item_load)
        begin
            kind_reg   <= kind;
            base_i_reg <= clip_base;
            len_i_reg  <= clip_samples;
            rate_i_reg <= clip_rate;
            enc_i_reg  <= clip_encoding;
            prio_i_reg <= priority_req;
            sa_i_reg   <= sample_a;
            sb_i_reg   <= sample_b;
            audio_reg  <= 16'sd0;
        end

        if (d_done)
        begin
            case (div_dst_reg)
                pcrp_pkg::DIV_FRAC_A:
                    fa_reg <= ({12'd0, fade} <= pos_reg) ? 17'h10000 : frac_q;
                pcrp_pkg::DIV_FRAC_R:
                    fr_reg <= ({12'd0, fade} <= rem_n) ? 17'h10000 : frac_q;
                default: fa_reg <= fa_reg;
            endcase
        end

        p_reg <= mul_a * mul_b;

        case (p_op_reg)
            pcrp_pkg::MUL_XA2:    x2a_reg <= p_reg[32:16];
            pcrp_pkg::MUL_XR2:    x2r_reg <= p_reg[32:16];
            pcrp_pkg::MUL_SA:     sa_reg <= p_reg[32:16];
            pcrp_pkg::MUL_SR:     sr_reg <= p_reg[32:16];
            pcrp_pkg::MUL_WAVE:   wave_reg <= wave_sum;
            pcrp_pkg::MUL_ENV:    env_reg <= p_reg[32:16];
            pcrp_pkg::MUL_GAIN15: v1_reg <= p_t7[31:0];
            pcrp_pkg::MUL_REL:
            begin
                if (rl_reg != 8'd0)
                    env_reg <= p_reg[23:7];
            end
            pcrp_pkg::MUL_V2:     v2_reg <= p_t16[31:0];
            pcrp_pkg::MUL_V3:     audio_reg <= sat_out;
            default:              v2_reg <= v2_reg;
        endcase

        if (cmd.out_load)
        begin
            audio_o_reg    <= audio_reg;
            rendered_o_reg <= rendered_reg;
            accepted_o_reg <= accepted_reg;
            playing_o_reg  <= active_reg;
            addr_a_o_reg   <= active_reg ? (cur_base_reg + {8'd0, ia}) : 32'd0;
            addr_b_o_reg   <= active_reg ? (cur_base_reg + {8'd0, ib}) : 32'd0;
        end
    end

    always_comb
    begin
        status.kind         = pcrp_pkg::kind_t'(kind_reg);
        status.active       = active_reg;
        status.play_start   = ok && !active_reg;
        status.tick_restart = ended && pend_valid_reg;
        status.div_done     = d_done;
    end

    assign audio_out    = audio_o_reg;
    assign rendered     = rendered_o_reg;
    assign accepted     = accepted_o_reg;
    assign playing      = playing_o_reg;
    assign fetch_addr_a = addr_a_o_reg;
    assign fetch_addr_b = addr_b_o_reg;

endmodule
`default_nettype wire

// File: design/pcrp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PCM clip player controller
// Sequences play, cancel and tick items through the datapath and owns the
// input and output handshakes.
// ----------------------------------------------------------------------------
module pcrp_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  wire logic              out_stall,
    input  wire pcrp_pkg::status_t status,
    output pcrp_pkg::cmd_t         cmd
);

    pcrp_pkg::state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic out_free;

    assign in_stall = (state_reg != pcrp_pkg::S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pcrp_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.div_op     = pcrp_pkg::DIV_PHASE;
        cmd.mul_op     = pcrp_pkg::MUL_NONE;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            pcrp_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.item_load = 1'b1;
                    state_next    = pcrp_pkg::S_DECODE;
                end
            end
            pcrp_pkg::S_DECODE:
            begin
                case (status.kind)
                    pcrp_pkg::KIND_PLAY:   state_next = pcrp_pkg::S_PLAY;
                    pcrp_pkg::KIND_CANCEL: state_next = pcrp_pkg::S_CANCEL;
                    pcrp_pkg::KIND_TICK:
                        state_next = status.active ? pcrp_pkg::S_T_FA : pcrp_pkg::S_FIN;
                    default:               state_next = pcrp_pkg::S_FIN;
                endcase
            end
            pcrp_pkg::S_PLAY:
            begin
                cmd.play_exec = 1'b1;
                state_next    = status.play_start ? pcrp_pkg::S_ST_DUR : pcrp_pkg::S_FIN;
            end
            pcrp_pkg::S_CANCEL:
            begin
                cmd.cancel = 1'b1;
                state_next = pcrp_pkg::S_FIN;
            end
            pcrp_pkg::S_ST_DUR:
            begin
                cmd.div_go = 1'b1;
                cmd.div_op = pcrp_pkg::DIV_DUR;
                state_next = pcrp_pkg::S_ST_DUR_W;
            end
            pcrp_pkg::S_ST_DUR_W:
                if (status.div_done) state_next = pcrp_pkg::S_FIN;
            pcrp_pkg::S_T_FA:
            begin
                cmd.div_go = 1'b1;
                cmd.div_op = pcrp_pkg::DIV_FRAC_A;
                state_next = pcrp_pkg::S_T_FA_W;
            end
            pcrp_pkg::S_T_FA_W:
                if (status.div_done) state_next = pcrp_pkg::S_T_FR;
            pcrp_pkg::S_T_FR:
            begin
                cmd.div_go = 1'b1;
                cmd.div_op = pcrp_pkg::DIV_FRAC_R;
                state_next = pcrp_pkg::S_T_FR_W;
            end
            pcrp_pkg::S_T_FR_W:
                if (status.div_done) state_next = pcrp_pkg::S_T_M1;
            pcrp_pkg::S_T_M1:
            begin
                cmd.mul_op = pcrp_pkg::MUL_XA2;
                state_next = pcrp_pkg::S_T_M2;
            end
            pcrp_pkg::S_T_M2:
            begin
                cmd.mul_op = pcrp_pkg::MUL_XR2;
                state_next = pcrp_pkg::S_T_M3;
            end
            pcrp_pkg::S_T_M3:
            begin
                cmd.mul_op = pcrp_pkg::MUL_SA;
                state_next = pcrp_pkg::S_T_M4;
            end
            pcrp_pkg::S_T_M4:
            begin
                cmd.mul_op = pcrp_pkg::MUL_SR;
                state_next = pcrp_pkg::S_T_M5;
            end
            pcrp_pkg::S_T_M5:
            begin
                cmd.mul_op = pcrp_pkg::MUL_WAVE;
                state_next = pcrp_pkg::S_T_M6;
            end
            pcrp_pkg::S_T_M6:
            begin
                cmd.mul_op = pcrp_pkg::MUL_ENV;
                state_next = pcrp_pkg::S_T_M7;
            end
            pcrp_pkg::S_T_M7:
            begin
                cmd.mul_op = pcrp_pkg::MUL_GAIN15;
                state_next = pcrp_pkg::S_T_M8;
            end
            pcrp_pkg::S_T_M8:
            begin
                cmd.mul_op = pcrp_pkg::MUL_REL;
                state_next = pcrp_pkg::S_T_M9;
            end
            pcrp_pkg::S_T_M9:
            begin
                // gain moves before it scales this sample
                cmd.gain_upd = 1'b1;
                state_next   = pcrp_pkg::S_T_M10;
            end
            pcrp_pkg::S_T_M10:
            begin
                cmd.mul_op = pcrp_pkg::MUL_V2;
                state_next = pcrp_pkg::S_T_M11;
            end
            pcrp_pkg::S_T_M11:
                state_next = pcrp_pkg::S_T_M12;
            pcrp_pkg::S_T_M12:
            begin
                cmd.mul_op = pcrp_pkg::MUL_V3;
                state_next = pcrp_pkg::S_T_M13;
            end
            pcrp_pkg::S_T_M13:
                state_next = pcrp_pkg::S_T_UPD;
            pcrp_pkg::S_T_UPD:
            begin
                cmd.tick_upd = 1'b1;
                state_next   = status.tick_restart ? pcrp_pkg::S_ST_DUR : pcrp_pkg::S_FIN;
            end
            pcrp_pkg::S_FIN:
            begin
                // hold until the result register is free
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = pcrp_pkg::S_IDLE;
                end
            end
            default: state_next = pcrp_pkg::S_IDLE;
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

// File: design/pcm_clip_resampling_player.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PCM clip resampling player
// Plays 8-bit PCM clips at 16 kHz with resampling, envelope and volume gain.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall) carries play, cancel and tick items; the
// output channel (out_valid/out_stall) returns one result per item. A tick
// carries the two bytes fetched at the addresses the previous result gave.
// Items are handled one at a time. Unused kinds, idle ticks, cancels and
// queued or refused plays need no division; a play that starts a clip runs
// one 38-step serial division; a rendering tick runs two 16-step fraction
// divisions plus a 13-step shared multiplier sequence, and one 38-step
// division more when it starts the pending clip. The next item is taken
// while a result waits in the output register; if the receiver stalls,
// the following item finishes and holds until that register frees. Reset
// clears the player to idle, volume 255, enabled. Registers must be written
// through cfg_we/cfg_index/cfg_data only while idle; the user must see to
// this, the block itself does not enforce it.
// ----------------------------------------------------------------------------
module pcm_clip_resampling_player (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic               cfg_index,
    input  wire logic [7:0]         cfg_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         kind,
    input  wire logic [31:0]        clip_base,
    input  wire logic [23:0]        clip_samples,
    input  wire logic [15:0]        clip_rate,
    input  wire logic [1:0]         clip_encoding,
    input  wire logic [1:0]         priority_req,
    input  wire logic [7:0]         sample_a,
    input  wire logic [7:0]         sample_b,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [15:0]      audio_out,
    output logic                    rendered,
    output logic                    accepted,
    output logic                    playing,
    output logic [31:0]             fetch_addr_a,
    output logic [31:0]             fetch_addr_b
);

    pcrp_pkg::cmd_t    cmd;
    pcrp_pkg::status_t status;

    pcrp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    pcrp_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .kind          (kind),
        .clip_base     (clip_base),
        .clip_samples  (clip_samples),
        .clip_rate     (clip_rate),
        .clip_encoding (clip_encoding),
        .priority_req  (priority_req),
        .sample_a      (sample_a),
        .sample_b      (sample_b),
        .audio_out     (audio_out),
        .rendered      (rendered),
        .accepted      (accepted),
        .playing       (playing),
        .fetch_addr_a  (fetch_addr_a),
        .fetch_addr_b  (fetch_addr_b)
    );

endmodule
`default_nettype wire
